/* sv/tun_pkg.sv */
package tun_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int FIELD_WIDTH      = 16;
  localparam int OUT_WIDTH        = 16;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] first_x;
    logic signed [FIELD_WIDTH-1:0] first_y;
    logic signed [FIELD_WIDTH-1:0] first_z;
    logic signed [FIELD_WIDTH-1:0] second_x;
    logic signed [FIELD_WIDTH-1:0] second_y;
    logic signed [FIELD_WIDTH-1:0] second_z;
    logic signed [FIELD_WIDTH-1:0] third_x;
    logic signed [FIELD_WIDTH-1:0] third_y;
    logic signed [FIELD_WIDTH-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_x;
    logic signed [OUT_WIDTH-1:0] normal_y;
    logic signed [OUT_WIDTH-1:0] normal_z;
    logic                        degenerate;
  } tri_out_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
    logic       degenerate;
  } tun_tag_t;

endpackage

/* sv/tun_front.sv */
module tun_front #(
  parameter int CW = tun_pkg::COORD_WIDTH,
  localparam int DW  = CW + 1,
  localparam int PW  = 2 * DW,
  localparam int MW  = PW,
  localparam int SQW = 2 * MW,
  localparam int SW  = SQW + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld,
  input  tun_pkg::tri_in_t vin,
  output logic [SQW-1:0]   sq [3],
  output logic [SW-1:0]    sum,
  output tun_pkg::tun_tag_t tag
);
  import tun_pkg::*;

  localparam int EW = (CW < FIELD_WIDTH) ? CW : FIELD_WIDTH;
  localparam int NW = PW + 1;
  localparam int H  = (MW + 1) / 2;
  localparam int HW = MW - H;

  logic signed [DW-1:0] va [3];
  logic signed [DW-1:0] vb [3];
  logic signed [DW-1:0] vc [3];

  // stage 1: edge vectors
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] w [3];
  // stage 2: cross products
  logic signed [PW-1:0] p [3];
  logic signed [PW-1:0] q [3];
  // stage 3: magnitudes
  logic [MW-1:0] mag [3];
  // stage 4: partial squares
  logic [2*HW-1:0] hh [3];
  logic [HW+H-1:0] hl [3];
  logic [2*H-1:0]  ll [3];
  // stage 5: squares
  logic [SQW-1:0] sq5 [3];

  tun_tag_t t1, t2, t3, t4, t5;
  logic [2:0] neg3;

  always_comb begin
    va[0] = DW'($signed(vin.first_x[EW-1:0]));
    va[1] = DW'($signed(vin.first_y[EW-1:0]));
    va[2] = DW'($signed(vin.first_z[EW-1:0]));
    vb[0] = DW'($signed(vin.second_x[EW-1:0]));
    vb[1] = DW'($signed(vin.second_y[EW-1:0]));
    vb[2] = DW'($signed(vin.second_z[EW-1:0]));
    vc[0] = DW'($signed(vin.third_x[EW-1:0]));
    vc[1] = DW'($signed(vin.third_y[EW-1:0]));
    vc[2] = DW'($signed(vin.third_z[EW-1:0]));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [NW-1:0] n;
      u[k] <= vb[k] - va[k];
      w[k] <= va[k] - vc[k];
      n = NW'(p[k]) - NW'(q[k]);
      mag[k] <= n[NW-1] ? MW'(-n) : MW'(n);
      neg3[k] <= n[NW-1];
      hh[k] <= mag[k][MW-1:H] * mag[k][MW-1:H];
      hl[k] <= mag[k][MW-1:H] * mag[k][H-1:0];
      ll[k] <= mag[k][H-1:0] * mag[k][H-1:0];
      sq5[k] <= (SQW'(hh[k]) << (2 * H)) + (SQW'(hl[k]) << (H + 1)) + SQW'(ll[k]);
      sq[k] <= sq5[k];
    end
    p[0] <= u[1] * w[2];
    q[0] <= u[2] * w[1];
    p[1] <= u[2] * w[0];
    q[1] <= u[0] * w[2];
    p[2] <= u[0] * w[1];
    q[2] <= u[1] * w[0];
    sum <= SW'(sq5[0]) + SW'(sq5[1]) + SW'(sq5[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      t5.valid <= 1'b0;
      tag.valid <= 1'b0;
    end else begin
      t1.valid <= vld;
      t2.valid <= t1.valid;
      t3.valid <= t2.valid;
      t4.valid <= t3.valid;
      t5.valid <= t4.valid;
      tag.valid <= t5.valid;
    end
    t1.neg <= '0;
    t1.degenerate <= 1'b0;
    t2.neg <= t1.neg;
    t2.degenerate <= t1.degenerate;
    t3.neg <= t2.neg;
    t3.degenerate <= t2.degenerate;
    // neg3 is registered alongside mag, in the same stage as t3
    t4.neg <= neg3;
    t4.degenerate <= t3.degenerate;
    t5.neg <= t4.neg;
    t5.degenerate <= t4.degenerate;
    tag.neg <= t5.neg;
    tag.degenerate <= t5.degenerate;
  end

endmodule

/* sv/tun_div.sv */
module tun_div #(
  parameter int F   = tun_pkg::NORMAL_FRAC_BITS,
  parameter int SQW = 68,
  parameter int SW  = SQW + 2,
  localparam int N  = 2 * F + 1
) (
  input  logic           clk,
  input  logic [SQW-1:0] num,
  input  logic [SW-1:0]  den,
  output logic [N-1:0]   quo
);
  import tun_pkg::*;

  localparam int RW = SW + 1;

  logic [RW-1:0] rem [N+1];
  logic [SW-1:0] dvs [N+1];
  logic [N-1:0]  qs  [N+1];

  assign rem[0] = RW'(num);
  assign dvs[0] = den;
  assign qs[0]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    if (i == 0) begin : g_first
      assign t = rem[i];
    end else begin : g_rest
      assign t = {rem[i][RW-2:0], 1'b0};
    end
    assign ge = t >= RW'(dvs[i]);
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? t - RW'(dvs[i]) : t;
      dvs[i+1] <= dvs[i];
      qs[i+1]  <= {qs[i][N-2:0], ge};
    end
  end

  assign quo = qs[N];

endmodule

/* sv/tun_sqrt.sv */
module tun_sqrt #(
  parameter int F = tun_pkg::NORMAL_FRAC_BITS,
  localparam int N = 2 * F + 1
) (
  input  logic         clk,
  input  logic [N-1:0] rad,
  output logic [F:0]   root
);
  import tun_pkg::*;

  localparam int K  = F + 1;
  localparam int XW = 2 * K;
  localparam int RW = F + 3;
  localparam int TW = RW + 2;

  logic [XW-1:0] x  [K+1];
  logic [RW-1:0] rm [K+1];
  logic [F:0]    rt [K+1];

  assign x[0]  = XW'(rad);
  assign rm[0] = '0;
  assign rt[0] = '0;

  for (genvar i = 0; i < K; i++) begin : g_step
    logic [TW-1:0] s;
    logic [TW-1:0] trial;
    logic          ge;
    assign s     = {rm[i], x[i][XW-1:XW-2]};
    assign trial = {(TW-2)'(rt[i]), 2'b01};
    assign ge    = s >= trial;
    always_ff @(posedge clk) begin
      rm[i+1] <= ge ? RW'(s - trial) : RW'(s);
      rt[i+1] <= {rt[i][F-1:0], ge};
      x[i+1]  <= {x[i][XW-3:0], 2'b00};
    end
  end

  assign root = rt[K];

endmodule

/* sv/triangle_unit_normal.sv */
// Triangle unit normal.
// A triangle (vertices A, B, C as Q8.8) is taken on the vertices port at a
// clock edge with start high and busy low. busy is always low: one item can
// enter in every cycle. The normal of (B-A) x (A-C), divided by its length,
// appears on the normal port as signed Q1.14 components rounded toward zero,
// with done high for exactly one cycle. A zero-length cross product gives a
// zero vector and sets degenerate.
// The pipeline holds the edge, cross product and squared-length stages, one
// stage per quotient bit of the restoring divider (2F+1), one stage per root
// bit of the square root (F+1) and the output register. Throughput is one
// item per cycle.
// Results appear in the order items were taken. The receiver cannot stall:
// a result is only present during its done cycle.
// Reset clears the valid bits of the pipeline; items in flight are dropped.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tun_pkg::tri_in_t  vertices,
  output logic              done,
  output tun_pkg::tri_out_t normal
);
  import tun_pkg::*;

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int DW   = COORD_WIDTH + 1;
  localparam int SQW  = 4 * DW;
  localparam int SW   = SQW + 2;
  localparam int N    = 2 * F + 1;
  localparam int DLY  = N + F + 1;
  localparam int LAT  = 6 + DLY + 1;

  logic [SQW-1:0] sq [3];
  logic [SW-1:0]  sum;
  tun_tag_t       ftag;
  tun_tag_t       tagd [DLY+1];
  logic [N-1:0]   quo  [3];
  logic [F:0]     root [3];
  logic signed [OUT_WIDTH-1:0] comp [3];

  assign busy = 1'b0;

  tun_front #(.CW(COORD_WIDTH)) u_front (
    .clk (clk),
    .rst (rst),
    .vld (start),
    .vin (vertices),
    .sq  (sq),
    .sum (sum),
    .tag (ftag)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tun_div #(.F(F), .SQW(SQW), .SW(SW)) u_div (
      .clk (clk),
      .num (sq[k]),
      .den (sum),
      .quo (quo[k])
    );
    tun_sqrt #(.F(F)) u_sqrt (
      .clk  (clk),
      .rad  (quo[k]),
      .root (root[k])
    );
    logic [F+1:0] qs;
    assign qs = tagd[DLY].neg[k] ? -{1'b0, root[k]} : {1'b0, root[k]};
    assign comp[k] = tagd[DLY].degenerate ? '0 : OUT_WIDTH'($signed(qs));
  end

  always_comb begin
    tagd[0] = ftag;
    tagd[0].degenerate = ~|sum;
  end

  for (genvar i = 0; i < DLY; i++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tagd[i+1].valid <= 1'b0;
      end else begin
        tagd[i+1].valid <= tagd[i].valid;
      end
      tagd[i+1].neg        <= tagd[i].neg;
      tagd[i+1].degenerate <= tagd[i].degenerate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tagd[DLY].valid;
    end
  end

  always_ff @(posedge clk) begin
    normal.normal_x   <= comp[0];
    normal.normal_y   <= comp[1];
    normal.normal_z   <= comp[2];
    normal.degenerate <= tagd[DLY].degenerate;
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an item");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    done && normal.degenerate |->
      normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
    else $error("degenerate result not zero");

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

/* sim/triangle_unit_normal_tb.sv */
`timescale 1ns / 1ps

module triangle_unit_normal_tb;
  import tun_pkg::*;

  localparam int TRI_BITS = $bits(tri_in_t);

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  tri_in_t  vertices = '0;
  logic     done;
  tri_out_t normal;

  tri_in_t  pending_tris[$];
  tri_out_t expected_normals[$];
  int       gap_left = 0;
  logic     burst = 1'b0;
  logic     failed = 1'b0;

  triangle_unit_normal DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertices(vertices), .done(done), .normal(normal)
  );

  always #2 clk = ~clk;

  function automatic tri_out_t unit_normal(tri_in_t v);
    logic signed [17:0]  ux, uy, uz, wx, wy, wz;
    logic signed [39:0]  n [3];
    logic signed [127:0] ns;
    logic [127:0]        sumsq, mag, rhs, cand;
    logic [15:0]         q;
    logic [15:0]         comp [3];
    tri_out_t            r;
    ux = 18'(v.second_x) - 18'(v.first_x);
    uy = 18'(v.second_y) - 18'(v.first_y);
    uz = 18'(v.second_z) - 18'(v.first_z);
    wx = 18'(v.first_x) - 18'(v.third_x);
    wy = 18'(v.first_y) - 18'(v.third_y);
    wz = 18'(v.first_z) - 18'(v.third_z);
    n[0] = 40'(uy) * 40'(wz) - 40'(uz) * 40'(wy);
    n[1] = 40'(uz) * 40'(wx) - 40'(ux) * 40'(wz);
    n[2] = 40'(ux) * 40'(wy) - 40'(uy) * 40'(wx);
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      ns = 128'(n[i]);
      sumsq += ns * ns;
    end
    r = '0;
    if (sumsq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      ns = 128'(n[i]);
      mag = ns[127] ? -ns : ns;
      rhs = (mag * mag) << (2 * NORMAL_FRAC_BITS);
      q = '0;
      for (int b = NORMAL_FRAC_BITS; b >= 0; b--) begin
        cand = 128'(q) | (128'd1 << b);
        if (cand * cand * sumsq <= rhs) q = cand[15:0];
      end
      comp[i] = ns[127] ? -q : q;
    end
    r.normal_x = comp[0];
    r.normal_y = comp[1];
    r.normal_z = comp[2];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_normals.push_back(unit_normal(vertices));
      if ($urandom_range(0, 63) == 0) burst <= ~burst;
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          vertices <= pending_tris.pop_front();
          start <= 1'b1;
          gap_left <= burst ? 0 : $urandom_range(0, 12);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tri_out_t exp_n;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected item %h", $time, normal);
        failed = 1'b1;
      end else begin
        exp_n = expected_normals.pop_front();
        if (normal.normal_x !== exp_n.normal_x) begin
          $display("%0t: normal_x exp %0d got %0d", $time, exp_n.normal_x, normal.normal_x);
          failed = 1'b1;
        end
        if (normal.normal_y !== exp_n.normal_y) begin
          $display("%0t: normal_y exp %0d got %0d", $time, exp_n.normal_y, normal.normal_y);
          failed = 1'b1;
        end
        if (normal.normal_z !== exp_n.normal_z) begin
          $display("%0t: normal_z exp %0d got %0d", $time, exp_n.normal_z, normal.normal_z);
          failed = 1'b1;
        end
        if (normal.degenerate !== exp_n.degenerate) begin
          $display("%0t: degenerate exp %0b got %0b", $time, exp_n.degenerate,
                   normal.degenerate);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic tri_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
    tri_in_t t;
    t.first_x = 16'(ax);  t.first_y = 16'(ay);  t.first_z = 16'(az);
    t.second_x = 16'(bx); t.second_y = 16'(by); t.second_z = 16'(bz);
    t.third_x = 16'(cx);  t.third_y = 16'(cy);  t.third_z = 16'(cz);
    return t;
  endfunction

  function automatic tri_in_t rand_tri();
    tri_in_t t;
    t = TRI_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return t;
  endfunction

  function automatic int near(int base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin
    tri_in_t t;
    int      ax, ay, az, sp;
    // directed
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                                    32767, -32768, 32767));
    pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, -32768, 32767,
                                    -32768, 32767, -32768));
    pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                    -32768, -32768, -32768));
    pending_tris.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, 5, 7, 9));
    pending_tris.push_back(make_tri(100, 200, 300, 101, 201, 302, 99, 199, 297));
    // random
    for (int i = 0; i < 1250; i++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          t = rand_tri();
        end
        2: begin
          sp = 1 << $urandom_range(0, 12);
          ax = int'($signed(16'($urandom))) / 2;
          ay = int'($signed(16'($urandom))) / 2;
          az = int'($signed(16'($urandom))) / 2;
          t = make_tri(ax, ay, az, near(ax, sp), near(ay, sp), near(az, sp),
                       near(ax, sp), near(ay, sp), near(az, sp));
        end
        3: begin
          t = rand_tri();
          case ($urandom_range(0, 2))
            0: begin
              t.second_x = t.first_x; t.second_y = t.first_y; t.second_z = t.first_z;
            end
            1: begin
              t.third_x = t.first_x; t.third_y = t.first_y; t.third_z = t.first_z;
            end
            default: begin
              t.third_x = t.second_x; t.third_y = t.second_y; t.third_z = t.second_z;
            end
          endcase
        end
        4: begin
          t = rand_tri();
          case ($urandom_range(0, 2))
            0: begin t.second_x = t.first_x; t.third_x = t.first_x; end
            1: begin t.second_y = t.first_y; t.third_y = t.first_y; end
            default: begin t.second_z = t.first_z; t.third_z = t.first_z; end
          endcase
        end
        default: begin
          ax = $urandom_range(0, 1) ? 32767 : -32768;
          t = rand_tri();
          if ($urandom_range(0, 1)) t.first_x = 16'(ax);
          if ($urandom_range(0, 1)) t.second_y = 16'(-ax - 1);
          if ($urandom_range(0, 1)) t.third_z = 16'(ax);
        end
      endcase
      pending_tris.push_back(t);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_tris.size() != 0 || start || expected_normals.size() != 0);
    repeat (80) @(posedge clk);
    if (!failed && expected_normals.size() == 0)
      $display("triangle_unit_normal_tb: done, clean");
    else
      $display("triangle_unit_normal_tb: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("triangle_unit_normal_tb: done, errors");
    $finish;
  end

endmodule
